[src/bspline_cost_gradient_eval_assert.svh]
// assertion macros used by the checker file
`ifndef BSPLINE_COST_GRADIENT_EVAL_ASSERT_SVH
`define BSPLINE_COST_GRADIENT_EVAL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCGE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCGE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bcge_pkg.sv]
// ----------------------------------------------------------------------------
// bcge_pkg
// Shared constants, types and saturation helpers of the B-spline cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcge_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int SPLINE_ORDER = 3;
	localparam int NSLOT        = SPLINE_ORDER + 1;
	localparam int COORD_W      = 32;
	localparam int GRAD_W       = 48;
	localparam int COST_W       = 63;
	localparam int IDX_W        = 16;

	// micro-operation codes, one shared product each but U_END
	localparam logic [4:0] U_J1  = 5'd0;
	localparam logic [4:0] U_J2  = 5'd1;
	localparam logic [4:0] U_J3  = 5'd2;
	localparam logic [4:0] U_V1  = 5'd3;
	localparam logic [4:0] U_V2  = 5'd4;
	localparam logic [4:0] U_V3  = 5'd5;
	localparam logic [4:0] U_V4  = 5'd6;
	localparam logic [4:0] U_V5  = 5'd7;
	localparam logic [4:0] U_V6  = 5'd8;
	localparam logic [4:0] U_V7  = 5'd9;
	localparam logic [4:0] U_A1  = 5'd10;
	localparam logic [4:0] U_A2  = 5'd11;
	localparam logic [4:0] U_A3  = 5'd12;
	localparam logic [4:0] U_A4  = 5'd13;
	localparam logic [4:0] U_A5  = 5'd14;
	localparam logic [4:0] U_A6  = 5'd15;
	localparam logic [4:0] U_A7  = 5'd16;
	localparam logic [4:0] U_END = 5'd17;

	// register indexes
	localparam logic [2:0] R_ENABLE = 3'd0;
	localparam logic [2:0] R_WS     = 3'd1;
	localparam logic [2:0] R_WF     = 3'd2;
	localparam logic [2:0] R_INV2   = 3'd3;
	localparam logic [2:0] R_INV4   = 3'd4;
	localparam logic [2:0] R_VLIM   = 3'd5;
	localparam logic [2:0] R_ALIM   = 3'd6;

	typedef struct packed {
		logic [1:0]  en;
		logic [31:0] ws;
		logic [31:0] wf;
		logic [31:0] inv2;
		logic [31:0] inv4;
		logic [31:0] vlim;
		logic [31:0] alim;
	} cfg_t;

	typedef struct packed {
		logic             accept;
		logic             mul_start;
		logic             wb;
		logic [4:0]       uop;
		logic [1:0]       axis;
		logic [IDX_W-1:0] k;
		logic             emit;
		logic [1:0]       emit_m;
		logic             emit_final;
		logic             commit;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic d_pos;
	} dp_sts_t;

	// clamp to signed 64 bits
	function automatic logic [63:0] sat64(input logic signed [67:0] x);
		if (x > 68'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		else if (x < 68'shF_8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		else
			return x[63:0];
	endfunction

	// clamp to signed 48 bits
	function automatic logic [GRAD_W-1:0] clamp48(input logic signed [67:0] x);
		if (x > 68'sh0_0000_7FFF_FFFF_FFFF)
			return 48'h7FFF_FFFF_FFFF;
		else if (x < 68'shF_FFFF_8000_0000_0000)
			return 48'h8000_0000_0000;
		else
			return x[GRAD_W-1:0];
	endfunction

endpackage

`default_nettype wire

[src/bcge_point_if.sv]
// ----------------------------------------------------------------------------
// bcge_point_if
// Control point channel: valid/ready with one 3D point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcge_point_if
	import bcge_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      last_point;

	modport source (output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

`default_nettype wire

[src/bcge_result_if.sv]
// ----------------------------------------------------------------------------
// bcge_result_if
// Result channel: valid/ready with one finished point gradient per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcge_result_if
	import bcge_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         point_index;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic signed [GRAD_W-1:0] grad_z;
	logic [COST_W-1:0]        total_cost;
	logic                     final_result;

	modport source (output valid, point_index, grad_x, grad_y, grad_z, total_cost,
		final_result, input ready);
	modport sink (input valid, point_index, grad_x, grad_y, grad_z, total_cost,
		final_result, output ready);
endinterface

`default_nettype wire

[src/bspline_cost_gradient_eval.sv]
// ----------------------------------------------------------------------------
// bspline_cost_gradient_eval
// Streaming cubic B-spline jerk and feasibility cost with per-point gradients.
// ----------------------------------------------------------------------------
// Usage
//   points  : one control point (Q16.16 x/y/z) per transfer, last_point ends
//             the sequence. ready is high only while the block is idle.
//   results : finished gradient of point k-3 once point k has been worked;
//             the last point flushes the open gradients oldest first, the
//             last result carrying final_result and the total cost.
//   APB     : seven 32-bit registers at byte offsets 0..24, written while idle.
// Timing
//   every product goes through one shared 64x64 unit built of four 32x32
//   partial products. A point needs 0 to 17 products per axis before any
//   result is offered, and each result waits for the receiver; the next
//   point is taken, through the commit state, after the last result of the
//   current one is transferred.
// Reset
//   registers return to their defaults, gradient and cost sums clear, and the
//   point count restarts at zero. A stalled receiver holds the result steady.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_cost_gradient_eval
	import bcge_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bcge_point_if.sink    points,
	bcge_result_if.source results,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en   <= 2'd3;
			cfg_q.ws   <= 32'd65536;
			cfg_q.wf   <= 32'd65536;
			cfg_q.inv2 <= 32'd65536;
			cfg_q.inv4 <= 32'd65536;
			cfg_q.vlim <= 32'd65536;
			cfg_q.alim <= 32'd65536;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				R_ENABLE: cfg_q.en   <= pwdata[1:0];
				R_WS:     cfg_q.ws   <= pwdata;
				R_WF:     cfg_q.wf   <= pwdata;
				R_INV2:   cfg_q.inv2 <= pwdata;
				R_INV4:   cfg_q.inv4 <= pwdata;
				R_VLIM:   cfg_q.vlim <= pwdata;
				R_ALIM:   cfg_q.alim <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			R_ENABLE: prdata = {30'd0, cfg_q.en};
			R_WS:     prdata = cfg_q.ws;
			R_WF:     prdata = cfg_q.wf;
			R_INV2:   prdata = cfg_q.inv2;
			R_INV4:   prdata = cfg_q.inv4;
			R_VLIM:   prdata = cfg_q.vlim;
			R_ALIM:   prdata = cfg_q.alim;
			default:  prdata = 32'd0;
		endcase
	end

	bcge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (cfg_q.en),
		.in_valid  (points.valid),
		.in_last   (points.last_point),
		.in_ready  (points.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcge_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.point_x      (points.point_x),
		.point_y      (points.point_y),
		.point_z      (points.point_z),
		.point_index  (results.point_index),
		.grad_x       (results.grad_x),
		.grad_y       (results.grad_y),
		.grad_z       (results.grad_z),
		.total_cost   (results.total_cost),
		.final_result (results.final_result)
	);

endmodule

`default_nettype wire

[src/bcge_mul.sv]
// ----------------------------------------------------------------------------
// bcge_mul
// Fixed-point 64x64 product over four 32x32 partial products, shifted by the
// fraction width, truncated toward zero and saturated to signed 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bcge_mul
	import bcge_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [127:0] acc_q;
	logic [127:0] pp_s1;
	logic         pv_s1;
	logic         done_q;
	logic [63:0]  prod_q;

	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] mag;
	logic [63:0]  res_c;

	// partial product select and alignment
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				pa = ua_q[31:0];
				pb = ub_q[31:0];
			end
			2'd1: begin
				pa = ua_q[63:32];
				pb = ub_q[31:0];
			end
			2'd2: begin
				pa = ua_q[31:0];
				pb = ub_q[63:32];
			end
			default: begin
				pa = ua_q[63:32];
				pb = ub_q[63:32];
			end
		endcase
		pp = 64'(pa) * 64'(pb);
		case (cnt_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// drop fraction bits, apply sign, saturate
	always_comb begin
		mag = acc_q >> FRAC_BITS;
		if (neg_q) begin
			if (mag > 128'h8000_0000_0000_0000)
				res_c = 64'h8000_0000_0000_0000;
			else
				res_c = 64'd0 - mag[63:0];
		end else begin
			if (mag > 128'h7FFF_FFFF_FFFF_FFFF)
				res_c = 64'h7FFF_FFFF_FFFF_FFFF;
			else
				res_c = mag[63:0];
		end
	end

	// sequence: four products, each registered before it is accumulated, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
				pv_s1  <= 1'b0;
			end else if (busy_q) begin
				pv_s1 <= ~cnt_q[2];
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= op_a[63] ? (64'd0 - op_a) : op_a;
			ub_q  <= op_b[63] ? (64'd0 - op_b) : op_b;
			neg_q <= op_a[63] ^ op_b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			pp_s1 <= pp_sh;
			if (pv_s1)
				acc_q <= acc_q + pp_s1;
			if (cnt_q == 3'd5)
				prod_q <= res_c;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

[src/bcge_ctrl.sv]
// ----------------------------------------------------------------------------
// bcge_ctrl
// Sequencer: walks the product program per axis, skips disabled or inactive
// terms, then emits finished gradients and commits the point.
// ----------------------------------------------------------------------------
`default_nettype none

module bcge_ctrl
	import bcge_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] en,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PICK   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_LOAD   = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;
	localparam logic [2:0] S_COMMIT = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [4:0]       uop_q, uop_d;
	logic [1:0]       axis_q, axis_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic [1:0]       had_q, had_d;
	logic             last_q, last_d;
	logic [1:0]       m_q, m_d;
	logic             tail_q, tail_d;

	logic jen, ven, aen;
	logic is_j, is_v, is_a;

	// term gating by mask and history
	always_comb begin
		jen  = en[0] && (had_q == 2'd3);
		ven  = en[1] && (had_q != 2'd0);
		aen  = en[1] && (had_q[1] == 1'b1);
		is_j = (uop_q <= U_J3);
		is_v = (uop_q >= U_V1) && (uop_q <= U_V7);
		is_a = (uop_q >= U_A1) && (uop_q <= U_A7);
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		uop_d   = uop_q;
		axis_d  = axis_q;
		k_d     = k_q;
		had_d   = had_q;
		last_d  = last_q;
		m_d     = m_q;
		tail_d  = tail_q;

		cmd            = '0;
		cmd.uop        = uop_q;
		cmd.axis       = axis_q;
		cmd.k          = k_q;
		cmd.emit_m     = m_q;
		cmd.emit_final = tail_q && (m_q == 2'd0);
		cmd.last       = last_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					last_d     = in_last;
					axis_d     = 2'd0;
					uop_d      = U_J1;
					state_d    = S_PICK;
				end
			end
			S_PICK: begin
				if (uop_q == U_END) begin
					if (axis_q == 2'd2) begin
						if (had_q == 2'd3) begin
							m_d     = 2'd3;
							tail_d  = 1'b0;
							state_d = S_LOAD;
						end else if (last_q) begin
							m_d     = had_q;
							tail_d  = 1'b1;
							state_d = S_LOAD;
						end else begin
							state_d = S_COMMIT;
						end
					end else begin
						axis_d = axis_q + 2'd1;
						uop_d  = U_J1;
					end
				end else if (is_j && !jen) begin
					uop_d = U_V1;
				end else if ((is_v && !ven) || (uop_q == U_V3 && !sts.d_pos)) begin
					uop_d = U_A1;
				end else if ((is_a && !aen) || (uop_q == U_A3 && !sts.d_pos)) begin
					uop_d = U_END;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (sts.mul_done) begin
					cmd.wb  = 1'b1;
					uop_d   = uop_q + 5'd1;
					state_d = S_PICK;
				end
			end
			S_LOAD: begin
				cmd.emit = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (!tail_q) begin
						if (last_q) begin
							tail_d  = 1'b1;
							m_d     = 2'd2;
							state_d = S_LOAD;
						end else begin
							state_d = S_COMMIT;
						end
					end else if (m_q == 2'd0) begin
						state_d = S_COMMIT;
					end else begin
						m_d     = m_q - 2'd1;
						state_d = S_LOAD;
					end
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				if (last_q) begin
					k_d   = '0;
					had_d = 2'd0;
				end else begin
					k_d   = k_q + 16'd1;
					had_d = (had_q == 2'd3) ? 2'd3 : had_q + 2'd1;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			uop_q   <= U_J1;
			axis_q  <= 2'd0;
			k_q     <= '0;
			had_q   <= 2'd0;
			last_q  <= 1'b0;
			m_q     <= 2'd0;
			tail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			uop_q   <= uop_d;
			axis_q  <= axis_d;
			k_q     <= k_d;
			had_q   <= had_d;
			last_q  <= last_d;
			m_q     <= m_d;
			tail_q  <= tail_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

`default_nettype wire

[src/bcge_dp.sv]
// ----------------------------------------------------------------------------
// bcge_dp
// Datapath: point window, shared fixed-point multiplier, temporaries, open
// gradient sums, cost sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcge_dp
	import bcge_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  dp_cmd_t                   cmd,
	output dp_sts_t                   sts,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic [IDX_W-1:0]          point_index,
	output logic signed [GRAD_W-1:0]  grad_x,
	output logic signed [GRAD_W-1:0]  grad_y,
	output logic signed [GRAD_W-1:0]  grad_z,
	output logic [COST_W-1:0]         total_cost,
	output logic                      final_result
);

	logic signed [COORD_W-1:0] p_q [3];
	logic signed [COORD_W-1:0] win_q [SPLINE_ORDER][3];
	logic signed [GRAD_W-1:0]  g_q [NSLOT][3];
	logic signed [63:0]        w_q, t_q, d_q;
	logic [COST_W-1:0]         cost_q;

	logic [IDX_W-1:0]          oidx_q;
	logic signed [GRAD_W-1:0]  ogx_q, ogy_q, ogz_q;
	logic [COST_W-1:0]         ocost_q;
	logic                      ofin_q;

	logic signed [35:0] q0, q1, q2, q3;
	logic signed [35:0] jk, vl, ac;
	logic [63:0]        op_a, op_b;
	logic               mul_done;
	logic [63:0]        mr;
	logic signed [67:0] r68, we, w2, w3;
	logic signed [GRAD_W-1:0] gnext [NSLOT];
	logic [1:0]         mrel [NSLOT];
	logic signed [67:0] gadd [NSLOT];
	logic [63:0]        csum;
	logic [IDX_W-1:0]   eidx;

	// differences of the current axis
	always_comb begin
		q0 = 36'(p_q[cmd.axis]);
		q1 = 36'(win_q[0][cmd.axis]);
		q2 = 36'(win_q[1][cmd.axis]);
		q3 = 36'(win_q[2][cmd.axis]);
		jk = q0 - 36'sd3 * q1 + 36'sd3 * q2 - q3;
		vl = q0 - q1;
		ac = q0 - 36'sd2 * q1 + q2;
	end

	// operand select per micro-operation
	always_comb begin
		case (cmd.uop)
			U_J1: begin
				op_a = {32'd0, cfg.ws};
				op_b = 64'(jk) <<< 1;
			end
			U_J2: begin
				op_a = 64'(jk);
				op_b = 64'(jk);
			end
			U_J3: begin
				op_a = {32'd0, cfg.ws};
				op_b = t_q;
			end
			U_V1: begin
				op_a = 64'(vl);
				op_b = 64'(vl);
			end
			U_V2: begin
				op_a = t_q;
				op_b = {32'd0, cfg.inv2};
			end
			U_V3: begin
				op_a = d_q;
				op_b = {32'd0, cfg.inv2};
			end
			U_V4: begin
				op_a = t_q;
				op_b = 64'(vl);
			end
			U_A1: begin
				op_a = 64'(ac);
				op_b = 64'(ac);
			end
			U_A2: begin
				op_a = t_q;
				op_b = {32'd0, cfg.inv4};
			end
			U_A3: begin
				op_a = d_q;
				op_b = {32'd0, cfg.inv4};
			end
			U_A4: begin
				op_a = t_q;
				op_b = 64'(ac);
			end
			U_V5, U_V7, U_A5, U_A7: begin
				op_a = {32'd0, cfg.wf};
				op_b = t_q;
			end
			U_V6, U_A6: begin
				op_a = d_q;
				op_b = d_q;
			end
			default: begin
				op_a = 64'd0;
				op_b = 64'd0;
			end
		endcase
	end

	bcge_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.op_a   (op_a),
		.op_b   (op_b),
		.done   (mul_done),
		.prod   (mr)
	);

	// gradient addends per slot, slot offset is age relative to point k
	always_comb begin
		r68  = 68'($signed(mr));
		we   = 68'(w_q);
		w2   = we <<< 1;
		w3   = w2 + we;
		csum = {1'b0, cost_q} + {1'b0, mr[62:0]};
		for (int s = 0; s < NSLOT; s++) begin
			mrel[s] = cmd.k[1:0] - 2'(s);
			case (cmd.uop)
				U_J3: begin
					case (mrel[s])
						2'd0:    gadd[s] = we;
						2'd1:    gadd[s] = -w3;
						2'd2:    gadd[s] = w3;
						default: gadd[s] = -we;
					endcase
				end
				U_V7: begin
					case (mrel[s])
						2'd0:    gadd[s] = we;
						2'd1:    gadd[s] = -we;
						default: gadd[s] = 68'sd0;
					endcase
				end
				default: begin
					case (mrel[s])
						2'd0:    gadd[s] = we;
						2'd1:    gadd[s] = -w2;
						2'd2:    gadd[s] = we;
						default: gadd[s] = 68'sd0;
					endcase
				end
			endcase
			gnext[s] = clamp48(68'(g_q[s][cmd.axis]) + gadd[s]);
		end
		eidx = cmd.k - IDX_W'(cmd.emit_m);
	end

	// temporaries and window
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q[0] <= point_x;
			p_q[1] <= point_y;
			p_q[2] <= point_z;
		end
		if (cmd.commit && !cmd.last) begin
			for (int a = 0; a < 3; a++) begin
				win_q[2][a] <= win_q[1][a];
				win_q[1][a] <= win_q[0][a];
				win_q[0][a] <= p_q[a];
			end
		end
		if (cmd.wb) begin
			case (cmd.uop)
				U_J1, U_V5, U_A5: w_q <= mr;
				U_V2: d_q <= sat64(r68 - $signed({36'd0, cfg.vlim}));
				U_A2: d_q <= sat64(r68 - $signed({36'd0, cfg.alim}));
				U_V4, U_A4: t_q <= sat64(r68 <<< 2);
				U_J2, U_V1, U_V3, U_V6, U_A1, U_A3, U_A6: t_q <= mr;
				default: ;
			endcase
		end
		if (cmd.emit) begin
			oidx_q  <= eidx;
			ogx_q   <= g_q[eidx[1:0]][0];
			ogy_q   <= g_q[eidx[1:0]][1];
			ogz_q   <= g_q[eidx[1:0]][2];
			ocost_q <= cmd.emit_final ? cost_q : '0;
			ofin_q  <= cmd.emit_final;
		end
	end

	// open gradient sums and cost sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NSLOT; s++)
				for (int a = 0; a < 3; a++)
					g_q[s][a] <= '0;
			cost_q <= '0;
		end else begin
			if (cmd.accept) begin
				for (int a = 0; a < 3; a++)
					g_q[cmd.k[1:0]][a] <= '0;
			end
			if (cmd.wb && (cmd.uop == U_J3 || cmd.uop == U_V7 || cmd.uop == U_A7)) begin
				for (int s = 0; s < NSLOT; s++)
					g_q[s][cmd.axis] <= gnext[s];
				if (!mr[63] && mr != 64'd0)
					cost_q <= csum[63] ? {COST_W{1'b1}} : csum[COST_W-1:0];
			end
			if (cmd.commit && cmd.last) begin
				for (int s = 0; s < NSLOT; s++)
					for (int a = 0; a < 3; a++)
						g_q[s][a] <= '0;
				cost_q <= '0;
			end
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.d_pos    = !d_q[63] && (d_q != 64'sd0);

	assign point_index  = oidx_q;
	assign grad_x       = ogx_q;
	assign grad_y       = ogy_q;
	assign grad_z       = ogz_q;
	assign total_cost   = ocost_q;
	assign final_result = ofin_q;

endmodule

`default_nettype wire

[src/bcge_checker.sv]
// ----------------------------------------------------------------------------
// bcge_checker
// Port-level checks of the cost block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bspline_cost_gradient_eval_assert.svh"

module bcge_checker
	import bcge_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [COST_W-1:0] out_cost,
	input logic              out_final
);

	// a pending result stays offered
	`BCGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// one point in flight: no intake while a result is offered
	`BCGE_ASSERT_SAME(a_excl, out_valid, !in_ready, "input ready while result pending")

	// a result never shows in the cycle after a point transfer
	`BCGE_ASSERT_NEXT(a_no_early, in_valid && in_ready, !out_valid, "result too early")

	// cost only rides on the final result
	`BCGE_ASSERT_SAME(a_cost_final, out_valid && !out_final, out_cost == '0, "cost on non-final")

endmodule

bind bspline_cost_gradient_eval bcge_checker u_bcge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_cost  (results.total_cost),
	.out_final (results.final_result)
);

`default_nettype wire
